// File: src/knob_dimmer_with_idle_fade_macros.svh
// Assertion macros used by the dimmer core (kdim_core).
`ifndef KNOB_DIMMER_WITH_IDLE_FADE_MACROS_SVH
`define KNOB_DIMMER_WITH_IDLE_FADE_MACROS_SVH

// Same-cycle implication.
`define KDIM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kdim check failed");

// Next-cycle implication.
`define KDIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kdim check failed");

`endif

// File: src/kdim_pkg.sv
package kdim_pkg;

    localparam int TICK_COUNTER_BITS = 32;

    localparam int SAMPLE_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_PERIOD = 2'd3;

    localparam logic [9:0]  RST_THRESHOLD   = 10'd8;
    localparam logic [31:0] RST_FADE_DELAY  = 32'd30000;
    localparam logic [31:0] RST_SETTLE      = 32'd3000;
    localparam logic [7:0]  RST_FADE_PERIOD = 8'd100;

    localparam logic [1:0] SEG_RED   = 2'd0;
    localparam logic [1:0] SEG_WHITE = 2'd1;
    localparam logic [1:0] SEG_GREEN = 2'd2;
    localparam logic [1:0] SEG_FULL  = 2'd3;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        logic [9:0]  threshold;
        logic [31:0] fade_delay;
        logic [31:0] settle_window;
        logic [7:0]  fade_period;
    } t_cfg;

endpackage

// File: src/kdim_cfg.sv
module kdim_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kdim_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kdim_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output kdim_pkg::t_cfg                     o_cfg
);
    import kdim_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= RST_THRESHOLD;
            r_cfg.fade_delay    <= RST_FADE_DELAY;
            r_cfg.settle_window <= RST_SETTLE;
            r_cfg.fade_period   <= RST_FADE_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:   r_cfg.threshold     <= i_cfg_wdata[9:0];
                CFG_FADE_DELAY:  r_cfg.fade_delay    <= i_cfg_wdata;
                CFG_SETTLE:      r_cfg.settle_window <= i_cfg_wdata;
                CFG_FADE_PERIOD: r_cfg.fade_period   <= i_cfg_wdata[7:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/kdim_core.sv
`include "knob_dimmer_with_idle_fade_macros.svh"

module kdim_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  kdim_pkg::t_op                  i_op,
    input  logic [kdim_pkg::SAMPLE_W-1:0]  i_sample,
    input  kdim_pkg::t_cfg                 i_cfg,
    output logic [kdim_pkg::SAMPLE_W-1:0]  o_level_next
);
    import kdim_pkg::*;

    logic [TICK_COUNTER_BITS-1:0] r_idle, n_idle;
    logic [SAMPLE_W-1:0]          r_ref, n_ref;
    logic [SAMPLE_W-1:0]          r_level, n_level;
    logic [7:0]                   r_fade_cnt, n_fade_cnt;

    logic signed [11:0]           w_diff;
    logic signed [11:0]           w_thr;
    logic                         w_active;
    logic [TICK_COUNTER_BITS-1:0] w_idle_eff;
    logic [TICK_COUNTER_BITS-1:0] w_idle_inc;
    logic [31:0]                  w_idle32;
    logic                         w_fade;
    logic                         w_track;
    logic [7:0]                   w_fade_inc;
    logic                         w_tick_step;
    logic                         w_smp_step;

    assign w_diff = $signed({2'b00, i_sample}) - $signed({2'b00, r_ref});
    assign w_thr  = $signed({2'b00, i_cfg.threshold});
    assign w_active = (w_diff > w_thr) || (w_diff <= -w_thr);

    assign w_idle_eff = w_active ? '0 : r_idle;
    assign w_idle_inc = r_idle + 1'b1;
    assign w_idle32   = 32'(w_idle_eff);
    assign w_fade     = w_idle32 > i_cfg.fade_delay;
    assign w_track    = w_idle32 < i_cfg.settle_window;
    assign w_fade_inc = r_fade_cnt + 8'd1;

    assign w_tick_step = i_step && (i_op == OP_TICK);
    assign w_smp_step  = i_step && (i_op == OP_SAMPLE);

    always_comb begin
        n_idle     = r_idle;
        n_ref      = r_ref;
        n_level    = r_level;
        n_fade_cnt = r_fade_cnt;
        if (i_step) begin
            unique case (i_op)
                OP_TICK: begin
                    if (r_idle != '1) begin
                        n_idle = w_idle_inc;
                    end
                end
                OP_SAMPLE: begin
                    n_idle = w_idle_eff;
                    if (w_active) begin
                        n_ref = i_sample;
                    end
                    priority if (w_fade) begin
                        if ((r_level != '0) && (w_fade_inc > i_cfg.fade_period)) begin
                            n_level    = r_level - 1'b1;
                            n_fade_cnt = '0;
                        end else begin
                            n_fade_cnt = w_fade_inc;
                        end
                    end else if (w_track) begin
                        n_level = i_sample;
                    end
                end
                default: n_idle = r_idle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle     <= '0;
            r_ref      <= '0;
            r_level    <= '0;
            r_fade_cnt <= '0;
        end else begin
            r_idle     <= n_idle;
            r_ref      <= n_ref;
            r_level    <= n_level;
            r_fade_cnt <= n_fade_cnt;
        end
    end

    assign o_level_next = n_level;

    `KDIM_ASSERT_NEXT(a_tick_counts, w_tick_step && (r_idle != '1), r_idle == $past(w_idle_inc))
    `KDIM_ASSERT_NEXT(a_tick_keeps_level, w_tick_step, $stable(r_level))
    `KDIM_ASSERT_NEXT(a_fade_one_step, w_smp_step && w_fade, ($past(r_level) - r_level) <= 10'd1)
    `KDIM_ASSERT_NEXT(a_activity_rearms, w_smp_step && w_active, (r_idle == '0) && (r_ref == $past(i_sample)))

endmodule

// File: src/kdim_curve.sv
module kdim_curve (
    input  logic [kdim_pkg::SAMPLE_W-1:0] i_level,
    output logic [31:0]                   o_grbw
);
    import kdim_pkg::*;

    logic [7:0] w_r, w_g, w_b, w_w;
    logic [7:0] w_low;

    assign w_low = i_level[7:0];

    always_comb begin
        unique case (i_level[9:8])
            SEG_RED: begin
                w_r = w_low;   w_g = 8'h00; w_b = 8'h00;            w_w = 8'h00;
            end
            SEG_WHITE: begin
                w_r = 8'hFF;   w_g = 8'h00; w_b = 8'h00;            w_w = w_low;
            end
            SEG_GREEN: begin
                w_r = 8'hFF;   w_g = w_low; w_b = {1'b0, w_low[7:1]}; w_w = 8'hFF;
            end
            SEG_FULL: begin
                w_r = ~w_low;  w_g = 8'hFF; w_b = 8'h7F;            w_w = ~w_low;
            end
            default: begin
                w_r = 8'h00;   w_g = 8'h00; w_b = 8'h00;            w_w = 8'h00;
            end
        endcase
    end

    assign o_grbw = {w_g, w_r, w_b, w_w};

endmodule

// File: src/knob_dimmer_with_idle_fade.sv
// channel  dir  handshake               contents
// s_axis   in   tvalid / tready         tdata: knob_sample; tuser: opcode
// m_axis   out  tvalid / tready         tdata: grbw_word, brightness_level
// cfg      in   i_cfg_we (no wait)      i_cfg_idx, i_cfg_wdata
//
// One item per cycle sustained unless a sample waits on a stalled output; a sample's result
// passes through the input register and then the output register, a tick gives no result.
// Ticks update the idle counter; samples update idle counter, reference, level and fade count.
// Reset (synchronous) clears the state and loads the register defaults.
// A stalled output holds the next sample in the input register; ticks still pass.
module knob_dimmer_with_idle_fade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [9:0] knob_sample
    input  logic [0:0]                      s_axis_tuser,  // [0] opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [47:0]                     m_axis_tdata,  // [31:0] grbw_word, [41:32] brightness_level
    input  logic                            i_cfg_we,
    input  logic [kdim_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kdim_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import kdim_pkg::*;

    logic                r_in_valid;
    t_op                 r_in_op;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_level;

    t_cfg                w_cfg;
    logic                w_adv;
    logic [SAMPLE_W-1:0] w_level_next;
    logic [31:0]         w_grbw;

    assign w_adv = r_in_valid &&
                   ((r_in_op == OP_TICK) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op     <= t_op'(s_axis_tuser[0]);
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    kdim_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    kdim_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_op         (r_in_op),
        .i_sample     (r_in_sample),
        .i_cfg        (w_cfg),
        .o_level_next (w_level_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && (r_in_op == OP_SAMPLE)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (r_in_op == OP_SAMPLE)) begin
            r_out_level <= w_level_next;
        end
    end

    kdim_curve u_curve (
        .i_level (r_out_level),
        .o_grbw  (w_grbw)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_level, w_grbw};

endmodule
